/* rtl/core/line_mark_detector_defines.svh */
// Assertion macros for the line mark detector.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef LINE_MARK_DETECTOR_DEFINES_SVH
`define LINE_MARK_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define LMD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_mark_detector: same-cycle check failed");
// Next-cycle implication.
`define LMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_mark_detector: next-cycle check failed");
`else
`define LMD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/lmd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lmd_pkg;

    localparam int SENSOR_COUNT = 16;
    localparam int WIN_W        = $clog2(SENSOR_COUNT);
    localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
    localparam int POS_W        = 17;
    localparam int ENC_W        = 32;
    localparam int LEN_W        = 16;
    localparam int THR_W        = 5;
    localparam int KIND_W       = 3;
    localparam int PHASE_W      = 2;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 16;

    localparam int IN_FIELDS_W  = SENSOR_COUNT + POS_W + 2 * ENC_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = KIND_W + PHASE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int POS_BASE = 30000;
    localparam int POS_STEP = 4000;

    localparam logic [LEN_W-1:0] MARK_LEN_RST   = 16'd256;
    localparam logic [THR_W-1:0] CENTRE_THR_RST = 5'd6;

    localparam logic [CFG_ADDR_W-1:0] CFG_MARK_LEN   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTRE_THR = 1'd1;

    localparam logic [SENSOR_COUNT-1:0] ALL_ON = 16'hFFFF;

    typedef logic [SENSOR_COUNT-1:0] t_sensor;

    typedef enum logic [PHASE_W-1:0] {
        PH_READY  = 2'd0,
        PH_ACCUM  = 2'd1,
        PH_DECIDE = 2'd2
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        MK_NONE  = 3'd0,
        MK_LEFT  = 3'd1,
        MK_RIGHT = 3'd2,
        MK_BOTH  = 3'd3,
        MK_CROSS = 3'd4
    } t_kind;

    localparam t_sensor LEFT_MASK [SENSOR_COUNT] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'hC000, 16'hE000, 16'hF000,
        16'h7800, 16'h3C00, 16'h1E00, 16'h0F00, 16'h0780, 16'h03C0, 16'h01E0, 16'h00F0
    };

    localparam t_sensor RIGHT_MASK [SENSOR_COUNT] = '{
        16'h0780, 16'h03C0, 16'h01E0, 16'h00F0, 16'h0078, 16'h003C, 16'h001E, 16'h000F,
        16'h0007, 16'h0003, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    localparam t_sensor CENTRE_MASK [SENSOR_COUNT] = '{
        16'hF800, 16'hFC00, 16'hFE00, 16'hFF00, 16'h7F80, 16'h3FC0, 16'h1FE0, 16'h0FF0,
        16'h07F8, 16'h03FC, 16'h01FE, 16'h00FF, 16'h007F, 16'h003F, 16'h001F, 16'h000F
    };

    // Count window boundaries at or below the position; saturates at both ends.
    function automatic logic [WIN_W-1:0] window_index(input logic signed [POS_W-1:0] pos);
        logic [WIN_W-1:0] idx;
        idx = '0;
        for (int k = 1; k < SENSOR_COUNT; k++) begin
            if (int'(pos) >= k * POS_STEP - POS_BASE) begin
                idx = idx + 1'b1;
            end
        end
        return idx;
    endfunction

    function automatic logic [CNT_W-1:0] popcount(input t_sensor v);
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            cnt = cnt + CNT_W'(v[i]);
        end
        return cnt;
    endfunction

    // Unsigned magnitude; the most negative count maps to 2^31.
    function automatic logic [ENC_W-1:0] magnitude(input logic [ENC_W-1:0] v);
        return v[ENC_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/line_mark_detector.sv */
// Line mark detector.
// Input stream s_axis: one word per sensor sample (sensor bits, line position,
// left and right encoder counts). Output stream m_axis: one word per input word,
// carrying the mark kind and the detector phase after that sample.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
// (0 mark length in encoder ticks, 1 centre hit threshold); write only while idle.
// From input accept to output valid a word passes through two registers:
// an input register that also holds the window index and wheel magnitudes, then
// the phase logic feeding the output register. One word is accepted per cycle
// while the output drains; the limit is the phase machine, which updates its
// state once per word.
// A stalled m_axis_tready holds the output word; s_axis_tready stays high until
// the input register is also full, so at most two words wait inside.
// Synchronous active-low reset empties both registers, puts the phase machine
// in ready with zero accumulated bits and target, and loads the register
// defaults (mark length 256, threshold 6).
`timescale 1ns / 1ps
`default_nettype none
`include "line_mark_detector_defines.svh"

module line_mark_detector (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [lmd_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire  [lmd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [15:0] sensor_bits, [32:16] line_position, [64:33] left_encoder,
    // [96:65] right_encoder, [103:97] zero
    input  wire  [lmd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // [2:0] mark_kind, [4:3] phase, [7:5] zero
    output logic [lmd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    import lmd_pkg::*;

    localparam int POS_LSB   = SENSOR_COUNT;
    localparam int LEFT_LSB  = POS_LSB + POS_W;
    localparam int RIGHT_LSB = LEFT_LSB + ENC_W;

    logic [LEN_W-1:0] r_mark_len;
    logic [THR_W-1:0] r_centre_thr;

    logic             r_in_valid;
    t_sensor          r_in_bits;
    logic [WIN_W-1:0] r_in_win;
    logic [ENC_W-1:0] r_mag_l;
    logic [ENC_W-1:0] r_mag_r;

    t_phase           r_phase,    n_phase;
    t_sensor          r_acc,      n_acc;
    logic             r_use_left, n_use_left;
    logic [ENC_W-1:0] r_target,   n_target;

    logic             r_out_valid;
    t_kind            r_out_kind, n_kind;
    t_phase           r_out_phase;

    logic             w_adv;
    logic             w_hit;
    logic             w_first_left;
    logic [ENC_W-1:0] w_mag_acc;
    logic [ENC_W-1:0] w_mag_new;
    t_sensor          w_lm, w_rm, w_cm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_len   <= MARK_LEN_RST;
            r_centre_thr <= CENTRE_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MARK_LEN:   r_mark_len   <= i_cfg_wdata[LEN_W-1:0];
                CFG_CENTRE_THR: r_centre_thr <= i_cfg_wdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // Capture the word with its window index and wheel magnitudes precomputed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_bits <= s_axis_tdata[SENSOR_COUNT-1:0];
            r_in_win  <= window_index(s_axis_tdata[LEFT_LSB-1:POS_LSB]);
            r_mag_l   <= magnitude(s_axis_tdata[RIGHT_LSB-1:LEFT_LSB]);
            r_mag_r   <= magnitude(s_axis_tdata[RIGHT_LSB+ENC_W-1:RIGHT_LSB]);
        end
    end

    always_comb begin
        w_lm         = LEFT_MASK[r_in_win];
        w_rm         = RIGHT_MASK[r_in_win];
        w_cm         = CENTRE_MASK[r_in_win];
        w_hit        = (|(r_in_bits & (w_lm | w_rm))) ||
                       (popcount(r_in_bits & w_cm) >= r_centre_thr);
        w_first_left = |(r_in_bits & w_lm);
        w_mag_acc    = r_use_left ? r_mag_l : r_mag_r;
        w_mag_new    = w_first_left ? r_mag_l : r_mag_r;
    end

    // Next state of the phase machine and its model state.
    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_use_left = r_use_left;
        n_target   = r_target;
        case (r_phase)
            PH_ACCUM: begin
                n_acc = r_acc | r_in_bits;
                if (r_target < w_mag_acc) begin
                    if (w_hit) begin
                        n_target = w_mag_acc + ENC_W'(r_mark_len >> 1);
                    end else begin
                        n_phase = PH_DECIDE;
                    end
                end
            end
            PH_DECIDE: begin
                n_phase = PH_READY;
            end
            default: begin
                n_phase = PH_READY;
                if (w_hit) begin
                    n_phase    = PH_ACCUM;
                    n_acc      = r_in_bits;
                    n_use_left = w_first_left;
                    n_target   = w_mag_new + ENC_W'(r_mark_len);
                end
            end
        endcase
    end

    // Result kind, reported only on the deciding step.
    always_comb begin
        n_kind = MK_NONE;
        case (r_phase)
            PH_DECIDE: begin
                if (r_acc == ALL_ON) begin
                    n_kind = MK_CROSS;
                end else if ((|(r_acc & w_lm)) && (|(r_acc & w_rm))) begin
                    n_kind = MK_BOTH;
                end else if (|(r_acc & w_lm)) begin
                    n_kind = MK_LEFT;
                end else if (|(r_acc & w_rm)) begin
                    n_kind = MK_RIGHT;
                end
            end
            default: begin
                n_kind = MK_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_READY;
            r_acc      <= '0;
            r_use_left <= 1'b0;
            r_target   <= '0;
        end else if (w_adv) begin
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_use_left <= n_use_left;
            r_target   <= n_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_kind  <= n_kind;
            r_out_phase <= n_phase;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), r_out_phase, r_out_kind};

    // A reported mark always comes with the machine back in ready.
    `LMD_ASSERT_NOW(a_kind_only_ready, i_clk, i_rst_n, r_out_valid && (r_out_kind != MK_NONE), r_out_phase == PH_READY)
    // Every processed word lands in the output register.
    `LMD_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid)
    // Deciding lasts exactly one processed word.
    `LMD_ASSERT_NEXT(a_decide_once, i_clk, i_rst_n, w_adv && (r_phase == PH_DECIDE), r_phase == PH_READY)
    // The output register mirrors the phase register after each step.
    `LMD_ASSERT_NEXT(a_out_phase_tracks, i_clk, i_rst_n, w_adv, r_out_phase == r_phase)

endmodule

`default_nettype wire

/* dv/tb_line_mark_detector.sv */
`timescale 1ns / 1ps

module tb_line_mark_detector;
    import lmd_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 9;

    typedef struct packed {
        t_sensor            sensor;
        logic signed [16:0] pos;
        logic [31:0]        enc_l;
        logic [31:0]        enc_r;
    } t_sample;

    typedef struct packed {
        t_kind  kind;
        t_phase phase;
    } t_mark_word;

    localparam t_sensor LEFT_WIN [16] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'hC000, 16'hE000, 16'hF000,
        16'h7800, 16'h3C00, 16'h1E00, 16'h0F00, 16'h0780, 16'h03C0, 16'h01E0, 16'h00F0
    };
    localparam t_sensor RIGHT_WIN [16] = '{
        16'h0780, 16'h03C0, 16'h01E0, 16'h00F0, 16'h0078, 16'h003C, 16'h001E, 16'h000F,
        16'h0007, 16'h0003, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };
    localparam t_sensor CENTRE_WIN [16] = '{
        16'hF800, 16'hFC00, 16'hFE00, 16'hFF00, 16'h7F80, 16'h3FC0, 16'h1FE0, 16'h0FF0,
        16'h07F8, 16'h03FC, 16'h01FE, 16'h00FF, 16'h007F, 16'h003F, 16'h001F, 16'h000F
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    line_mark_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // detector copy: registers and phase machine
    logic [15:0] mark_len_q   = MARK_LEN_RST;
    logic [4:0]  centre_thr_q = CENTRE_THR_RST;
    t_phase      phase_q      = PH_READY;
    t_sensor     acc_bits_q   = '0;
    logic        use_left_q   = 1'b0;
    logic [31:0] target_q     = '0;

    t_sample    sample_q[$];
    t_mark_word mark_exp_q[$];
    t_sample    on_bus;
    int         in_gap = 0;
    int         out_stall = 0;
    bit         in_burst = 0;
    bit         out_burst = 0;
    int         samples_sent = 0;
    int         marks_checked = 0;
    int         mismatches = 0;
    int         idle_cycles = 0;
    int         kind_seen [5] = '{0, 0, 0, 0, 0};

    function automatic int window_of(input int p);
        int c;
        c = p;
        if (c < -30000) c = -30000;
        if (c > 33999) c = 33999;
        return (c + 30000) / 4000;
    endfunction

    function automatic logic [31:0] wheel_mag(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic t_mark_word step_detector(input t_sample s);
        int          w;
        logic [31:0] mag_l;
        logic [31:0] mag_r;
        logic [31:0] mag;
        t_sensor     lm;
        t_sensor     rm;
        t_sensor     cm;
        logic        hit;
        logic        is_l;
        logic        is_r;
        t_mark_word  r;
        w     = window_of(int'(s.pos));
        mag_l = wheel_mag(s.enc_l);
        mag_r = wheel_mag(s.enc_r);
        lm    = LEFT_WIN[w];
        rm    = RIGHT_WIN[w];
        cm    = CENTRE_WIN[w];
        hit   = ((s.sensor & (lm | rm)) != '0) ||
                ($countones(s.sensor & cm) >= int'(centre_thr_q));
        r.kind = MK_NONE;
        case (phase_q)
            PH_ACCUM: begin
                acc_bits_q = acc_bits_q | s.sensor;
                mag = use_left_q ? mag_l : mag_r;
                if (target_q < mag) begin
                    if (hit) begin
                        target_q = mag + {17'd0, mark_len_q[15:1]};
                    end else begin
                        phase_q = PH_DECIDE;
                    end
                end
            end
            PH_DECIDE: begin
                is_l = (acc_bits_q & lm) != '0;
                is_r = (acc_bits_q & rm) != '0;
                phase_q = PH_READY;
                if (acc_bits_q == ALL_ON) r.kind = MK_CROSS;
                else if (is_l && is_r)    r.kind = MK_BOTH;
                else if (is_l)            r.kind = MK_LEFT;
                else if (is_r)            r.kind = MK_RIGHT;
            end
            default: begin
                phase_q = PH_READY;
                if (hit) begin
                    phase_q    = PH_ACCUM;
                    acc_bits_q = s.sensor;
                    use_left_q = (s.sensor & lm) != '0;
                    mag        = use_left_q ? mag_l : mag_r;
                    target_q   = mag + {16'd0, mark_len_q};
                end
            end
        endcase
        r.phase = phase_q;
        return r;
    endfunction

    function automatic int draw_idle(input bit burst);
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    // driver: present queued samples, predict on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            in_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                mark_exp_q.push_back(step_detector(on_bus));
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    on_bus = sample_q.pop_front();
                    s_axis_tdata  <= {7'd0, on_bus.enc_r, on_bus.enc_l, on_bus.pos,
                                      on_bus.sensor};
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
                    in_gap = draw_idle(in_burst);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall at random, compare each word with the oldest expectation
    always @(posedge i_clk) begin
        t_mark_word exp_w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            out_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (mark_exp_q.size() == 0) begin
                    $display("%0t: unexpected word kind=%0d phase=%0d", $time,
                             m_axis_tdata[2:0], m_axis_tdata[4:3]);
                    mismatches++;
                end else begin
                    exp_w = mark_exp_q.pop_front();
                    marks_checked++;
                    kind_seen[exp_w.kind]++;
                    if (m_axis_tdata[2:0] !== exp_w.kind) begin
                        $display("%0t: mark_kind expected %0d got %0d", $time,
                                 exp_w.kind, m_axis_tdata[2:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[4:3] !== exp_w.phase) begin
                        $display("%0t: phase expected %0d got %0d", $time,
                                 exp_w.phase, m_axis_tdata[4:3]);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
                out_stall = draw_idle(out_burst);
            end
            if (out_stall > 0) begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic bit drained();
        return sample_q.size() == 0 && !s_axis_tvalid && mark_exp_q.size() == 0;
    endfunction

    task automatic wait_drained();
        while (!drained()) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= 16'(val);
        if (idx == CFG_MARK_LEN) mark_len_q = 16'(val);
        else centre_thr_q = 5'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_sample(input t_sensor s, input int p, input logic [31:0] l,
                                input logic [31:0] r);
        t_sample smp;
        smp.sensor = s;
        smp.pos    = 17'(p);
        smp.enc_l  = l;
        smp.enc_r  = r;
        sample_q.push_back(smp);
    endtask

    // mostly driving runs over marks with walking encoders; some noise bursts
    task automatic queue_drive(input int count);
        int          made;
        int          seg;
        int          p;
        int          w;
        int          step_max;
        int          dl;
        int          dr;
        int          mark_run;
        int          mark_sel;
        logic [31:0] el;
        logic [31:0] er;
        t_sensor     s;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 4) == 0) begin
                seg = $urandom_range(1, 5);
                repeat (seg) begin
                    queue_sample(16'($urandom), $urandom_range(0, 131071) - 65536,
                                 $urandom, $urandom);
                end
                made += seg;
            end else begin
                p = $urandom_range(0, 70000) - 35000;
                // two blank words with large wheel counts walk the machine back to ready
                queue_sample('0, p, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                queue_sample('0, p, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                el = $urandom_range(0, 2000000);
                er = $urandom_range(0, 2000000);
                if ($urandom_range(0, 1)) el = 32'd0 - el;
                if ($urandom_range(0, 1)) er = 32'd0 - er;
                if ($urandom_range(0, 9) == 0) el = 32'h7FFF_0000;
                dl = $urandom_range(0, 3) == 0 ? -1 : 1;
                dr = $urandom_range(0, 3) == 0 ? -1 : 1;
                step_max = int'(mark_len_q) / 6 + 2;
                mark_run = 0;
                mark_sel = 0;
                seg = $urandom_range(10, 40);
                repeat (seg) begin
                    p += $urandom_range(0, 2000) - 1000;
                    if (p < -40000) p = -40000;
                    if (p > 44000) p = 44000;
                    w = window_of(p);
                    if (mark_run == 0 && $urandom_range(0, 7) == 0) begin
                        mark_run = $urandom_range(1, 10);
                        mark_sel = $urandom_range(0, 3);
                    end
                    s = 16'($urandom) & CENTRE_WIN[w];
                    if (mark_run > 0) begin
                        case (mark_sel)
                            0: s = s | LEFT_WIN[w];
                            1: s = s | RIGHT_WIN[w];
                            2: s = s | LEFT_WIN[w] | RIGHT_WIN[w];
                            default: s = ALL_ON;
                        endcase
                        mark_run--;
                    end
                    if ($urandom_range(0, 3) == 0) s = s & 16'($urandom);
                    el = el + 32'(dl * $urandom_range(0, step_max));
                    er = er + 32'(dr * $urandom_range(0, step_max));
                    queue_sample(s, p, el, er);
                end
                made += seg + 2;
            end
        end
    endtask

    int len_set [PHASES] = '{1, 65535, 256, 40, 7, 0, 3000, 0, 65535};
    int thr_set [PHASES] = '{1, 16, 6, 0, 31, 0, 3, 10, 1};

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults; window index 7 at position 0
        queue_sample('0, -65536, 32'd0, 32'd0);
        queue_sample('0, 65535, 32'd0, 32'd0);
        queue_sample('0, -30000, 32'd0, 32'd0);
        queue_sample('0, 33999, 32'h8000_0000, 32'h7FFF_FFFF);
        // cross
        queue_sample(16'hFFFF, 0, 32'd0, 32'd0);
        queue_sample('0, 0, 32'd300, 32'd0);
        queue_sample('0, 0, 32'd0, 32'd0);
        // left mark with a target extension
        queue_sample(16'hF000, 0, 32'd100, 32'd0);
        queue_sample(16'hF000, 0, 32'd400, 32'd0);
        queue_sample('0, 0, 32'd500, 32'd0);
        queue_sample('0, 0, -32'sd600, 32'd0);
        queue_sample('0, 0, 32'd0, 32'd0);
        // right mark, most negative count on the right wheel
        queue_sample(16'h000F, 0, 32'd0, -32'sd10);
        queue_sample('0, 0, 32'd0, 32'h8000_0000);
        queue_sample('0, 0, 32'd0, 32'd0);
        // both
        queue_sample(16'hF00F, 0, 32'd0, 32'd0);
        queue_sample('0, 0, 32'd1000, 32'd0);
        queue_sample('0, 0, 32'd0, 32'd0);
        // centre window hit at threshold, then one below
        queue_sample(16'h03F0, 0, 32'd0, 32'd0);
        queue_sample('0, 0, 32'd0, 32'd257);
        queue_sample('0, 0, 32'd0, 32'd0);
        queue_sample(16'h01F0, 0, 32'd0, 32'd0);
        wait_drained();

        len_set[5] = $urandom_range(1, 65535);
        thr_set[5] = $urandom_range(1, 16);
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_MARK_LEN, len_set[ph]);
            write_reg(CFG_CENTRE_THR, thr_set[ph]);
            queue_drive(190);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mark_exp_q.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, mark_exp_q.size());
            mismatches++;
        end
        $display("covered %0d samples over %0d register settings, %0d words compared",
                 samples_sent, PHASES + 1, marks_checked);
        $display("marks expected: cross %0d both %0d left %0d right %0d, none %0d",
                 kind_seen[MK_CROSS], kind_seen[MK_BOTH], kind_seen[MK_LEFT],
                 kind_seen[MK_RIGHT], kind_seen[MK_NONE]);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* line_mark_detector.f */
+incdir+rtl/core
rtl/core/lmd_pkg.sv
rtl/core/line_mark_detector.sv
dv/tb_line_mark_detector.sv
